// ===== rtl/core/srf_pkg.sv =====
// Package for the sample ring buffer: op codes, field widths, constants
// and the stage word passed from the control stage to the output stage.
// No dependencies.
package srf_pkg;

   localparam int SAMPLE_W = 8;
   localparam int FILL_W   = 13;
   localparam int CNT_W    = 32;

   localparam logic [SAMPLE_W-1:0] SILENCE = 8'h80;
   localparam logic [CNT_W-1:0]    CNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_RX     = 2'd0,
      OP_STROBE = 2'd1,
      OP_STATS  = 2'd2
   } srf_op_type;

   // One item after pointer/counter update, waiting for the ring read data
   typedef struct packed {
      logic              rd;        // sample comes from ring read data
      logic              underrun;
      logic [FILL_W-1:0] fill;
      logic [CNT_W-1:0]  strobes;
      logic [CNT_W-1:0]  unders;
   } srf_stage_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ===== rtl/core/srf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module srf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srf_ctrl.sv =====
// Accept stage: pointers, saturating counters, ring write/read issue and
// the stage register that waits for ring read data. Uses srf_pkg.
module srf_ctrl
   import srf_pkg::*;
#(
   parameter int RING_ADDR_BITS = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [1:0]                in_op,
   input  logic [SAMPLE_W-1:0]       in_byte,
   output logic                      ram_wr_en,
   output logic [RING_ADDR_BITS-1:0] ram_wr_addr,
   output logic [SAMPLE_W-1:0]       ram_wr_data,
   output logic                      ram_rd_en,
   output logic [RING_ADDR_BITS-1:0] ram_rd_addr,
   output logic                      stage_valid,
   input  logic                      stage_ready,
   output srf_stage_type             stage
);

   localparam int DIFF_W = (RING_ADDR_BITS > FILL_W) ? RING_ADDR_BITS : FILL_W;

   logic [RING_ADDR_BITS-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]          str_ff, str_in, und_ff, und_in;
   logic                      s1_valid_ff, s1_valid_in;
   srf_stage_type             s1_ff, s1_in;

   srf_op_type                op;
   logic                      accept, empty, is_rx, is_read, is_under, is_stats;
   logic [CNT_W-1:0]          str_upd, und_upd;
   logic [RING_ADDR_BITS-1:0] diff;
   logic [DIFF_W-1:0]         diff_ext;

   assign op       = srf_op_type'(in_op);
   assign in_ready = !s1_valid_ff || stage_ready;
   assign accept   = in_valid && in_ready;
   assign empty    = (rp_ff == wp_ff);

   always_comb begin
      is_rx    = 1'b0;
      is_read  = 1'b0;
      is_under = 1'b0;
      is_stats = 1'b0;
      case (op)
         OP_RX:     is_rx = 1'b1;
         OP_STROBE: begin
            is_read  = !empty;
            is_under = empty;
         end
         OP_STATS:  is_stats = 1'b1;
         default:   ;
      endcase
   end

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      str_upd = str_ff;
      und_upd = und_ff;
      if (accept && is_rx) begin
         wp_in = wp_ff + RING_ADDR_BITS'(1);
      end
      if (accept && is_read) begin
         rp_in   = rp_ff + RING_ADDR_BITS'(1);
         str_upd = sat_inc(str_ff);
      end
      if (accept && is_under) begin
         und_upd = sat_inc(und_ff);
      end
      str_in = (accept && is_stats) ? '0 : str_upd;
      und_in = (accept && is_stats) ? '0 : und_upd;

      // fill after this item's pointer update, low bits only
      diff     = wp_in - rp_in;
      diff_ext = DIFF_W'(diff);

      s1_in.rd       = is_read;
      s1_in.underrun = is_under;
      s1_in.fill     = diff_ext[FILL_W-1:0];
      s1_in.strobes  = str_upd;
      s1_in.unders   = und_upd;

      s1_valid_in = accept ? 1'b1 : (stage_ready ? 1'b0 : s1_valid_ff);
   end

   assign ram_wr_en   = accept && is_rx;
   assign ram_wr_addr = wp_ff;
   assign ram_wr_data = in_byte;
   assign ram_rd_en   = accept && is_read;
   assign ram_rd_addr = rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         str_ff      <= '0;
         und_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         str_ff      <= str_in;
         und_ff      <= und_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign stage_valid = s1_valid_ff;
   assign stage       = s1_ff;

   a_rd_excl: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_ff.rd && s1_ff.underrun))
      else $error("stage word marked both read and underrun");

   a_empty_under: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_STROBE && empty) |=> (s1_valid_ff && s1_ff.underrun
                                                && $stable(rp_ff)))
      else $error("strobe on empty ring not flagged as underrun");

   a_wp_adv: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_RX) |=> (wp_ff == $past(wp_ff) + RING_ADDR_BITS'(1)))
      else $error("write pointer did not advance on received byte");

endmodule

// ===== rtl/core/srf_out.sv =====
// Output stage: resolves the sample from ring read data or the held
// sample, keeps the held sample, and registers the result word. Uses srf_pkg.
module srf_out
   import srf_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              stage_valid,
   output logic                              stage_ready,
   input  srf_stage_type                     stage,
   input  logic [SAMPLE_W-1:0]               ram_rd_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [SAMPLE_W+1+FILL_W+2*CNT_W-1:0] out_data
);

   localparam int DATA_W = SAMPLE_W + 1 + FILL_W + 2 * CNT_W;

   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [SAMPLE_W-1:0] held_ff, held_in, sample;
   logic                move;

   assign stage_ready = !out_valid_ff || out_ready;
   assign move        = stage_valid && stage_ready;
   assign sample      = stage.rd ? ram_rd_data : held_ff;

   always_comb begin
      held_in      = (move && stage.rd) ? ram_rd_data : held_ff;
      data_in      = {stage.unders, stage.strobes, stage.fill, stage.underrun, sample};
      out_valid_in = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         held_ff      <= SILENCE;
      end else begin
         out_valid_ff <= out_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/sample_ring_fifo_hold_last.sv =====
// Sample ring buffer with hold-last output, top level.
// Depends on srf_pkg, srf_ram, srf_ctrl and srf_out.
//
// Input stream (req_): one word per event. req_tuser selects the kind:
// received byte (req_tdata is written into the ring), output strobe
// (next ring byte, or the held sample with underrun set if the ring is
// empty) and statistics (fill level and both counters, then counters
// cleared). Every input word gives exactly one result word on rsp_.
// A write never checks for overrun; a full lap makes the ring read empty.
// The ring's registered read and the stage word load at the accepting
// edge, the output register when the stage word moves on; rsp_tvalid
// rises once the output register holds the result.
// Throughput: one word per cycle while rsp_tready is high, bounded by the
// single ring write port and single read port, each used at most once per word.
// Reset clears both pointers and counters and sets the held sample to
// 0x80; ring contents are not cleared and need no sweep.
// When rsp_tready is low the result word holds, one more word waits in
// the read stage, and req_tready drops once both are occupied.
module sample_ring_fifo_hold_last
   import srf_pkg::*;
#(
   parameter int RING_ADDR_BITS = 13
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // [7:0] sample_out, [8] underrun,
                                    // [21:9] fill_level, [53:22] strobes_seen,
                                    // [85:54] underruns_seen, [87:86] zero
);

   localparam int DATA_W = SAMPLE_W + 1 + FILL_W + 2 * CNT_W;
   localparam int DEPTH  = 1 << RING_ADDR_BITS;

   logic                      ram_wr_en, ram_rd_en;
   logic [RING_ADDR_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_W-1:0]       ram_wr_data, ram_rd_data;
   logic                      stage_valid, stage_ready;
   srf_stage_type             stage;
   logic [DATA_W-1:0]         out_data;

   srf_ctrl #(
      .RING_ADDR_BITS(RING_ADDR_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_byte     (req_tdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   srf_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   srf_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .ram_rd_data (ram_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (out_data)
   );

   assign rsp_tdata = {2'b00, out_data};

endmodule
